// ----- design/ipe_pkg.sv -----
// Shared constants and types for the pick-from-either-end game evaluator.
`timescale 1ns / 1ps
`default_nettype none
package ipe_pkg;

    localparam int MAX_PILES_DEF  = 512;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed widths of the ports.
    localparam int PILE_W   = 16;
    localparam int MARGIN_W = 26;

    // Signed range of the score_margin port.
    localparam int MARGIN_HI = 33554431;
    localparam int MARGIN_LO = -33554432;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } ipe_state_t;

endpackage : ipe_pkg
`default_nettype wire

// ----- design/ipe_ram.sv -----
// Synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module ipe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule : ipe_ram
`default_nettype wire

// ----- design/ipe_step.sv -----
// One cell of the interval recurrence: best of taking the left or the right pile.
`timescale 1ns / 1ps
`default_nettype none
module ipe_step #(
    parameter int VW = 16,
    parameter int MW = 27
) (
    input  wire logic        [VW-1:0] pile_left,
    input  wire logic        [VW-1:0] pile_right,
    input  wire logic signed [MW-1:0] margin_inner_left,   // span without the left pile
    input  wire logic signed [MW-1:0] margin_inner_right,  // span without the right pile
    output logic signed      [MW-1:0] best
);

    logic signed [MW-1:0] left_ext;
    logic signed [MW-1:0] right_ext;
    logic signed [MW-1:0] take_left;
    logic signed [MW-1:0] take_right;

    assign left_ext   = MW'($signed({1'b0, pile_left}));
    assign right_ext  = MW'($signed({1'b0, pile_right}));
    assign take_left  = left_ext - margin_inner_left;
    assign take_right = right_ext - margin_inner_right;
    assign best       = (take_left > take_right) ? take_left : take_right;

endmodule : ipe_step
`default_nettype wire

// ----- design/interval_dp_pick_ends_game.sv -----
// Top level of the pick-from-either-end game evaluator.
//
// Piles stream in at one per cycle in the load state and are written to a
// pile RAM and, as the one-pile margins, to a margin RAM. The item flagged
// is_last closes the row; the block then stops taking input and sweeps the
// spans longest-last, each cell reading both RAMs in its READ state and
// writing the new margin back in the WRITE state after it, as the margin RAM
// round-trip demands. DONE then hands the result to the output register once
// that register is free. Input is taken again as soon as the result sits in
// the output register, even while it waits for out_ready. Piles past
// MAX_PILES are dropped and reported through overflowed.
`timescale 1ns / 1ps
`default_nettype none
module interval_dp_pick_ends_game #(
    parameter int MAX_PILES  = ipe_pkg::MAX_PILES_DEF,
    parameter int VALUE_BITS = ipe_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [ipe_pkg::PILE_W-1:0]   pile_value,
    input  wire logic                                is_last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     first_wins,
    output logic signed      [ipe_pkg::MARGIN_W-1:0] score_margin,
    output logic                                     overflowed
);

    import ipe_pkg::*;

    localparam int VW = (VALUE_BITS < PILE_W) ? VALUE_BITS : PILE_W;
    localparam int AW = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
    localparam int CW = $clog2(MAX_PILES + 1);
    localparam int MW = VW + CW + 1;
    localparam int XW = (MW > MARGIN_W) ? MW : MARGIN_W;

    localparam logic signed [XW-1:0] SAT_HI   = XW'(MARGIN_HI);
    localparam logic signed [XW-1:0] SAT_LO   = XW'(MARGIN_LO);
    localparam logic        [CW-1:0] CNT_FULL = CW'(MAX_PILES);

    ipe_state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg;
    logic                 ovf_reg;
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        k_reg;
    logic signed [MW-1:0] ans_reg;
    logic                 out_valid_reg;
    logic                 first_wins_reg;
    logic [MARGIN_W-1:0]  score_reg;
    logic                 overflowed_reg;

    logic                 in_fire;
    logic                 room;
    logic                 out_load;
    logic                 step_last;
    logic                 pass_last;
    logic [VW-1:0]        value;
    logic [CW-1:0]        j_idx;
    logic [CW-1:0]        i_plus1;

    logic                 pile_we;
    logic                 marg_we;
    logic [AW-1:0]        marg_waddr;
    logic [MW-1:0]        marg_wdata;
    logic [VW-1:0]        pile_rd_a;
    logic [VW-1:0]        pile_rd_b;
    logic [MW-1:0]        marg_rd_a;
    logic [MW-1:0]        marg_rd_b;
    logic signed [MW-1:0] best;
    logic signed [XW-1:0] ans_x;
    logic signed [XW-1:0] sat;

    assign value     = pile_value[VW-1:0];
    assign room      = (cnt_reg < CNT_FULL);
    assign in_fire   = in_valid && in_ready;
    assign j_idx     = i_reg + k_reg - CW'(1);
    assign i_plus1   = i_reg + CW'(1);
    assign step_last = (({1'b0, i_reg} + {1'b0, k_reg}) == {1'b0, cnt_reg});
    assign pass_last = (k_reg == cnt_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && is_last)
                begin
                    state_next = (cnt_reg == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = (step_last && pass_last) ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        out_load   = 1'b0;
        pile_we    = 1'b0;
        marg_we    = 1'b0;
        marg_waddr = cnt_reg[AW-1:0];
        marg_wdata = MW'($signed({1'b0, value}));
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                pile_we  = in_valid && room;
                marg_we  = in_valid && room;
            end
            ST_READ:
            begin
                marg_we = 1'b0;
            end
            ST_WRITE:
            begin
                marg_we    = 1'b1;
                marg_waddr = i_reg[AW-1:0];
                marg_wdata = best;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_fire)
            begin
                if (room)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                i_reg <= '0;
                k_reg <= CW'(2);
            end
            else if (state_reg == ST_WRITE)
            begin
                // Advance along the pass, or start the next longer span length.
                if (step_last)
                begin
                    i_reg <= '0;
                    k_reg <= k_reg + CW'(1);
                end
                else
                begin
                    i_reg <= i_plus1;
                end
            end
            else if (out_load)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the final margin; a single-pile row takes the pile itself.
    always_ff @(posedge clk)
    begin
        if (in_fire && is_last && (cnt_reg == '0))
        begin
            ans_reg <= MW'($signed({1'b0, value}));
        end
        else if ((state_reg == ST_WRITE) && step_last && pass_last)
        begin
            ans_reg <= best;
        end
    end

    // Clamp to the port range; the sign flag uses the exact margin.
    always_comb
    begin
        ans_x = XW'(ans_reg);
        sat   = ans_x;
        if (ans_x > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (ans_x < SAT_LO)
        begin
            sat = SAT_LO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            first_wins_reg <= (ans_reg > MW'(0));
            score_reg      <= sat[MARGIN_W-1:0];
            overflowed_reg <= ovf_reg;
        end
    end

    ipe_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_PILES),
        .AW    (AW)
    ) u_pile_ram (
        .clk     (clk),
        .we      (pile_we),
        .waddr   (cnt_reg[AW-1:0]),
        .wdata   (value),
        .raddr_a (i_reg[AW-1:0]),
        .raddr_b (j_idx[AW-1:0]),
        .rdata_a (pile_rd_a),
        .rdata_b (pile_rd_b)
    );

    ipe_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_PILES),
        .AW    (AW)
    ) u_margin_ram (
        .clk     (clk),
        .we      (marg_we),
        .waddr   (marg_waddr),
        .wdata   (marg_wdata),
        .raddr_a (i_reg[AW-1:0]),
        .raddr_b (i_plus1[AW-1:0]),
        .rdata_a (marg_rd_a),
        .rdata_b (marg_rd_b)
    );

    ipe_step #(
        .VW (VW),
        .MW (MW)
    ) u_step (
        .pile_left          (pile_rd_a),
        .pile_right         (pile_rd_b),
        .margin_inner_left  ($signed(marg_rd_b)),
        .margin_inner_right ($signed(marg_rd_a)),
        .best               (best)
    );

    assign out_valid    = out_valid_reg;
    assign first_wins   = first_wins_reg;
    assign score_margin = $signed(score_reg);
    assign overflowed   = overflowed_reg;

endmodule : interval_dp_pick_ends_game
`default_nettype wire
